FILE: hw/rtl/eps_pkg.sv
// Shared types and constants for the even position sorter.
package eps_pkg;

  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned MAX_ITEMS_DEF = 64;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_res;
    logic                      last_res;
    logic                      overflowed;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic last_pos;
  } sts_t;

endpackage

FILE: hw/rtl/eps_ctrl.sv
// Control state machine: load phase, emit phase and output valid.
module eps_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_last_i,
  input  logic         out_stall_i,
  input  eps_pkg::sts_t sts_i,
  output eps_pkg::cmd_t cmd_o,
  output logic         in_stall_o,
  output logic         out_valid_o
);
  import eps_pkg::*;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    in_stall_o = (state_q != ST_LOAD);
    cmd_o.load = in_valid_i && (state_q == ST_LOAD);
    cmd_o.pop  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
    state_d    = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (cmd_o.load && in_last_i) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd_o.pop && sts_i.last_pos) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
    if (cmd_o.pop) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/eps_datapath.sv
// Datapath: sorted insertion chain for even positions, queue for odd ones.
module eps_datapath #(
  parameter int unsigned MAX_ITEMS = eps_pkg::MAX_ITEMS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  eps_pkg::cmd_t     cmd_i,
  input  eps_pkg::in_item_t in_item_i,
  output eps_pkg::sts_t     sts_o,
  output eps_pkg::out_item_t out_item_o
);
  import eps_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_ITEMS + 1);
  localparam int unsigned NEV   = (MAX_ITEMS + 1) / 2;
  localparam int unsigned NOD   = (MAX_ITEMS > 1) ? MAX_ITEMS / 2 : 1;

  logic signed [VALUE_W-1:0] ev_q [NEV];
  logic signed [VALUE_W-1:0] ev_d [NEV];
  logic signed [VALUE_W-1:0] od_q [NOD];
  logic signed [VALUE_W-1:0] od_d [NOD];
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] ev_cnt;
  logic [CW-1:0] half;
  logic          ovf_q, ovf_d;
  logic          room;
  logic [NEV-1:0] lt;
  out_item_t     out_q, out_d;

  assign room   = (count_q < CW'(MAX_ITEMS));
  assign half   = count_q >> 1;
  assign ev_cnt = half + CW'(count_q[0]);
  assign sts_o.last_pos = ((pos_q + CW'(1)) == count_q);

  // lt[k]: new value goes at or before cell k (empty cells count as +inf)
  always_comb begin
    for (int k = 0; k < NEV; k++) begin
      lt[k] = (CW'(k) >= ev_cnt) || (in_item_i.value < ev_q[k]);
    end
  end

  always_comb begin
    ev_d    = ev_q;
    od_d    = od_q;
    count_d = count_q;
    pos_d   = pos_q;
    ovf_d   = ovf_q;
    out_d   = out_q;
    if (cmd_i.load) begin
      if (room) begin
        count_d = count_q + CW'(1);
        if (!count_q[0]) begin
          for (int k = 0; k < NEV; k++) begin
            if (lt[k]) begin
              if (k == 0) begin
                ev_d[k] = in_item_i.value;
              end else begin
                ev_d[k] = lt[k-1] ? ev_q[k-1] : in_item_i.value;
              end
            end
          end
        end else begin
          for (int k = 0; k < NOD; k++) begin
            if (CW'(k) == half) od_d[k] = in_item_i.value;
          end
        end
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.pop) begin
      out_d.value_res  = pos_q[0] ? od_q[0] : ev_q[0];
      out_d.last_res   = sts_o.last_pos;
      out_d.overflowed = ovf_q;
      if (pos_q[0]) begin
        for (int k = 0; k < NOD - 1; k++) od_d[k] = od_q[k+1];
      end else begin
        for (int k = 0; k < NEV - 1; k++) ev_d[k] = ev_q[k+1];
      end
      if (sts_o.last_pos) begin
        count_d = '0;
        pos_d   = '0;
        ovf_d   = 1'b0;
      end else begin
        pos_d = pos_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q  <= ev_d;
    od_q  <= od_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      pos_q   <= pos_d;
      ovf_q   <= ovf_d;
    end
  end

  assign out_item_o = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ITEMS))
    else $error("element count above capacity");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q < count_q) || (count_q == '0 && pos_q == '0))
    else $error("emit position past batch end");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == CW'(MAX_ITEMS)))
    else $error("overflow flagged with store not full");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop && sts_o.last_pos) |=> (count_q == '0 && !ovf_q))
    else $error("batch state not cleared after final transfer");

endmodule

FILE: hw/rtl/even_position_sorter_unit.sv
// Top level of the even position sorter: control and datapath.
//
// Input channel: in_valid_i / in_stall_o carry one element (value, last)
// per transfer. Elements of a batch are taken one per cycle; the final
// element has last set. Even positions go into a sorted insertion chain,
// odd positions into a queue. Elements past MAX_ITEMS are dropped and
// overflowed is set on every result of that batch.
// Output channel: out_valid_o / out_stall_i carry one result per transfer
// in position order, last_res on the final one.
// out_valid_o rises once the control state machine has entered its emit
// state and the first result is held in the output register; results
// follow at one per cycle while the receiver does not stall.
// During emission in_stall_o is high, so a batch is fully loaded before
// it is emitted and the next batch waits until emission ends. The last
// result leaves the output register while the next batch loads.
// Reset clears the batch count, the overflow flag and the output valid.
// A stall holds the output register and pauses emission.
module even_position_sorter_unit #(
  parameter int unsigned MAX_ITEMS = eps_pkg::MAX_ITEMS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  eps_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output eps_pkg::out_item_t out_item_o
);
  import eps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  eps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.last),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o)
  );

  eps_datapath #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_item_i (in_item_i),
    .sts_o     (sts),
    .out_item_o(out_item_o)
  );

endmodule

FILE: dv/even_position_sorter_unit_tb.sv
// Testbench for even_position_sorter_unit: directed table plus random batches, checked by a predictor.
`timescale 1ns / 1ps

module even_position_sorter_unit_tb;
  import eps_pkg::*;

  localparam int          MAX_ITEMS   = MAX_ITEMS_DEF;
  localparam int          HOLD_CYCLES = 300;
  localparam int          WDOG_LIMIT  = 2000;
  localparam int          PHASE_ITEMS = 112;
  localparam logic [31:0] VAL_MIN     = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX     = 32'h7fff_ffff;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        typed;
    logic [31:0] typed_val;
  } dir_row_t;

  localparam int NUM_ROWS = 22;
  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    '{VAL_MIN,      1'b1, 1'b1, VAL_MIN},
    '{VAL_MAX,      1'b1, 1'b1, VAL_MAX},
    '{32'h0,        1'b1, 1'b1, 32'h0},
    '{32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff},
    '{32'd7,        1'b0, 1'b0, 32'h0},
    '{32'd100,      1'b0, 1'b0, 32'h0},
    '{-32'sd3,      1'b0, 1'b0, 32'h0},
    '{VAL_MIN,      1'b0, 1'b0, 32'h0},
    '{VAL_MAX,      1'b1, 1'b0, 32'h0},
    '{VAL_MAX,      1'b0, 1'b0, 32'h0},
    '{VAL_MIN,      1'b1, 1'b0, 32'h0},
    '{32'd5,        1'b0, 1'b0, 32'h0},
    '{32'd1,        1'b0, 1'b0, 32'h0},
    '{32'd5,        1'b0, 1'b0, 32'h0},
    '{32'd2,        1'b0, 1'b0, 32'h0},
    '{-32'sd5,      1'b0, 1'b0, 32'h0},
    '{32'd3,        1'b0, 1'b0, 32'h0},
    '{32'd0,        1'b1, 1'b0, 32'h0},
    '{32'd1,        1'b0, 1'b0, 32'h0},
    '{32'd1,        1'b1, 1'b0, 32'h0},
    '{32'h5555_5555, 1'b0, 1'b0, 32'h0},
    '{32'haaaa_aaaa, 1'b1, 1'b0, 32'h0}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_stall_i = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  logic signed [31:0] batch_mem [MAX_ITEMS];
  int unsigned        batch_len     = 0;
  logic               batch_dropped = 1'b0;
  out_item_t          fresh_results [$];
  out_item_t          due_results   [$];
  out_item_t          want_res;

  int errors     = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_req   = 0;
  int hold_done  = 0;
  int hold_left  = 0;
  int wdog_cnt   = 0;
  int items_sent = 0;

  even_position_sorter_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stores one element; on the final one sorts even positions and queues the expected results.
  function automatic void take_element(input in_item_t it);
    int unsigned        i;
    int unsigned        j;
    logic signed [31:0] tmp;
    fresh_results.delete();
    if (batch_len < MAX_ITEMS) begin
      batch_mem[batch_len] = it.value;
      batch_len++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (!it.last) return;
    for (i = 0; i < batch_len; i += 2) begin
      for (j = i; j < batch_len; j += 2) begin
        if (batch_mem[i] > batch_mem[j]) begin
          tmp          = batch_mem[i];
          batch_mem[i] = batch_mem[j];
          batch_mem[j] = tmp;
        end
      end
    end
    for (i = 0; i < batch_len; i++) begin
      fresh_results.push_back('{value_res: batch_mem[i], last_res: (i + 1 == batch_len),
                                overflowed: batch_dropped});
    end
    batch_len     = 0;
    batch_dropped = 1'b0;
  endfunction

  task automatic send_elem(input logic [31:0] val, input logic lst, input logic typed,
                           input logic [31:0] typed_val);
    in_item_t it;
    it = '{value: val, last: lst};
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    take_element(it);
    if (typed)
      due_results.push_back('{value_res: typed_val, last_res: 1'b1, overflowed: 1'b0});
    else
      foreach (fresh_results[k]) due_results.push_back(fresh_results[k]);
    items_sent++;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3:    return $urandom_range(8) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_batch(input int len);
    for (int n = 0; n < len; n++) send_elem(rand_value(), n == len - 1, 1'b0, 32'h0);
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req != hold_done) begin
      hold_done   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d last %0b ovf %0b",
                 $time, out_item_o.value_res, out_item_o.last_res, out_item_o.overflowed);
        errors++;
      end else begin
        want_res = due_results.pop_front();
        if (out_item_o.value_res !== want_res.value_res) begin
          $display("%0t: value_res expected %0d got %0d", $time, want_res.value_res,
                   out_item_o.value_res);
          errors++;
        end
        if (out_item_o.last_res !== want_res.last_res) begin
          $display("%0t: last_res expected %0b got %0b", $time, want_res.last_res,
                   out_item_o.last_res);
          errors++;
        end
        if (out_item_o.overflowed !== want_res.overflowed) begin
          $display("%0t: overflowed expected %0b got %0b", $time, want_res.overflowed,
                   out_item_o.overflowed);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        wdog_cnt <= 0;
      end else if (wdog_cnt >= WDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WDOG_LIMIT);
        $display("[even_position_sorter_unit] ERROR");
        $finish;
      end else begin
        wdog_cnt <= wdog_cnt + 1;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[r])
      send_elem(DIR_ROWS[r].value, DIR_ROWS[r].last, DIR_ROWS[r].typed, DIR_ROWS[r].typed_val);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; hold_req++; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      // full store, then overflow on the final element, then overflow before it
      case (ph)
        1: send_batch(MAX_ITEMS);
        2: send_batch(MAX_ITEMS + 1);
        3: send_batch(MAX_ITEMS + 6);
        default: ;
      endcase
      while (items_sent < NUM_ROWS + (ph + 1) * PHASE_ITEMS)
        send_batch(($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12));
    end
    in_valid_i <= 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0)
      $display("[even_position_sorter_unit] OK");
    else
      $display("[even_position_sorter_unit] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/eps_pkg.sv
hw/rtl/eps_ctrl.sv
hw/rtl/eps_datapath.sv
hw/rtl/even_position_sorter_unit.sv
dv/even_position_sorter_unit_tb.sv
